FILE: hdl/rpi_pkg.sv
// ----------------------------------------------------------------------------
// rpi_pkg
// Shared types, codes and defaults of the ray / polygon intersection block.
// ----------------------------------------------------------------------------
package rpi_pkg;

    localparam int MAX_VERTICES_DEF = 16;

    // configuration register indexes
    localparam logic [2:0] CFG_NORMAL_X = 3'd0;
    localparam logic [2:0] CFG_NORMAL_Y = 3'd1;
    localparam logic [2:0] CFG_NORMAL_Z = 3'd2;
    localparam logic [2:0] CFG_AXIS     = 3'd3;
    localparam logic [2:0] CFG_VCOUNT   = 3'd4;
    localparam logic [2:0] CFG_EPS      = 3'd5;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    localparam logic [0:0] FUNC_LOAD = 1'b0;
    localparam logic [0:0] FUNC_TEST = 1'b1;

    // datapath operations
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_CAPT   = 4'd2;
    localparam logic [3:0] OP_DEN    = 4'd3;
    localparam logic [3:0] OP_NUM    = 4'd4;
    localparam logic [3:0] OP_DIVT   = 4'd5;
    localparam logic [3:0] OP_DIVE   = 4'd6;
    localparam logic [3:0] OP_DSTEP  = 4'd7;
    localparam logic [3:0] OP_TFIN   = 4'd8;
    localparam logic [3:0] OP_PX     = 4'd9;
    localparam logic [3:0] OP_PY     = 4'd10;
    localparam logic [3:0] OP_ESHIFT = 4'd11;
    localparam logic [3:0] OP_TOG    = 4'd12;
    localparam logic [3:0] OP_XC     = 4'd13;
    localparam logic [3:0] OP_RES    = 4'd14;
    localparam logic [3:0] OP_ZERO   = 4'd15;

    // multiplier operand pairs
    localparam logic [3:0] SEL_NXDX = 4'd0;
    localparam logic [3:0] SEL_NYDY = 4'd1;
    localparam logic [3:0] SEL_NZDZ = 4'd2;
    localparam logic [3:0] SEL_NXOX = 4'd3;
    localparam logic [3:0] SEL_NYOY = 4'd4;
    localparam logic [3:0] SEL_NZOZ = 4'd5;
    localparam logic [3:0] SEL_DA_T = 4'd6;
    localparam logic [3:0] SEL_DB_T = 4'd7;
    localparam logic [3:0] SEL_EDGE = 4'd8;

    // accumulator actions
    localparam logic [1:0] ACC_NONE = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    typedef struct packed {
        logic [3:0] op;
        logic       mul_en;
        logic [3:0] sel;
        logic [1:0] acc;
        logic       rd_en;
    } t_cmd;

    typedef struct packed {
        logic par;
        logic rng;
        logic skip;
        logic right;
        logic horiz;
    } t_sts;

endpackage

FILE: hdl/rpi_ctrl.sv
// ----------------------------------------------------------------------------
// rpi_ctrl
// Sequencer: issues vertex loads and steps the datapath through plane cut,
// t division, projection and the edge crossing pass.
// ----------------------------------------------------------------------------
module rpi_ctrl #(
    parameter int AW = 4,
    parameter int CW = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           i_func,
    input  rpi_pkg::t_sts  i_sts,
    input  logic [CW-1:0]  i_n_edges,
    output rpi_pkg::t_cmd  o_cmd,
    output logic [AW-1:0]  o_rd_idx,
    output logic           busy
);
    import rpi_pkg::*;

    localparam int EW = CW + 1;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DEN    = 5'd1;
    localparam logic [4:0] S_PAR    = 5'd2;
    localparam logic [4:0] S_NUM    = 5'd3;
    localparam logic [4:0] S_DIVI   = 5'd4;
    localparam logic [4:0] S_DIV    = 5'd5;
    localparam logic [4:0] S_TFIN   = 5'd6;
    localparam logic [4:0] S_RNG    = 5'd7;
    localparam logic [4:0] S_PROJ   = 5'd8;
    localparam logic [4:0] S_EFIRST = 5'd9;
    localparam logic [4:0] S_ECLS   = 5'd10;
    localparam logic [4:0] S_EDIV   = 5'd11;
    localparam logic [4:0] S_EMUL   = 5'd12;
    localparam logic [4:0] S_EXC    = 5'd13;
    localparam logic [4:0] S_ENEXT  = 5'd14;
    localparam logic [4:0] S_DONE   = 5'd15;
    localparam logic [4:0] S_MISS   = 5'd16;

    logic [4:0]    r_state, n_state;
    logic [4:0]    r_cnt, n_cnt;
    logic [AW-1:0] r_eidx, n_eidx;
    logic [EW-1:0] nxt2;
    logic          last_edge;

    assign busy      = (r_state != S_IDLE);
    assign nxt2      = EW'(r_eidx) + EW'(2);
    assign last_edge = ((EW'(r_eidx) + EW'(1)) == EW'(i_n_edges));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_eidx  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_eidx  <= n_eidx;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_eidx   = r_eidx;
        o_cmd    = '{op: OP_NONE, mul_en: 1'b0, sel: SEL_NXDX, acc: ACC_NONE, rd_en: 1'b0};
        o_rd_idx = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_func == FUNC_TEST) begin
                        o_cmd.op    = OP_CAPT;
                        o_cmd.rd_en = 1'b1;
                        n_state     = S_DEN;
                        n_cnt       = '0;
                    end else begin
                        o_cmd.op = OP_LOAD;
                    end
                end
            end
            S_DEN, S_NUM: begin
                o_cmd.mul_en = (r_cnt < 5'd3);
                o_cmd.sel    = ((r_state == S_DEN) ? SEL_NXDX : SEL_NXOX) + r_cnt[3:0];
                if (r_cnt == 5'd1) begin
                    o_cmd.acc = ACC_LOAD;
                end else if (r_cnt == 5'd2 || r_cnt == 5'd3) begin
                    o_cmd.acc = ACC_ADD;
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd4) begin
                    o_cmd.op = (r_state == S_DEN) ? OP_DEN : OP_NUM;
                    n_state  = (r_state == S_DEN) ? S_PAR : S_DIVI;
                    n_cnt    = '0;
                end
            end
            S_PAR: begin
                n_state = i_sts.par ? S_MISS : S_NUM;
            end
            S_DIVI: begin
                o_cmd.op = OP_DIVT;
                n_state  = S_DIV;
                n_cnt    = '0;
            end
            S_DIV, S_EDIV: begin
                o_cmd.op = OP_DSTEP;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = (r_state == S_DIV) ? S_TFIN : S_EMUL;
                end
            end
            S_TFIN: begin
                o_cmd.op = OP_TFIN;
                n_state  = S_RNG;
            end
            S_RNG: begin
                n_state = i_sts.rng ? S_MISS : S_PROJ;
                n_cnt   = '0;
            end
            S_PROJ: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd0) begin
                    o_cmd.mul_en = 1'b1;
                    o_cmd.sel    = SEL_DA_T;
                end else if (r_cnt == 5'd1) begin
                    o_cmd.mul_en = 1'b1;
                    o_cmd.sel    = SEL_DB_T;
                    o_cmd.op     = OP_PX;
                end else begin
                    o_cmd.op    = OP_PY;
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_EFIRST;
                end
            end
            S_EFIRST: begin
                o_cmd.op = OP_ESHIFT;
                n_eidx   = '0;
                if (i_n_edges == '0) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_idx    = (EW'(1) < EW'(i_n_edges)) ? AW'(1) : '0;
                    n_state     = S_ECLS;
                end
            end
            S_ECLS: begin
                if (i_sts.skip || i_sts.horiz) begin
                    n_state = S_ENEXT;
                end else if (i_sts.right) begin
                    o_cmd.op = OP_TOG;
                    n_state  = S_ENEXT;
                end else begin
                    o_cmd.op = OP_DIVE;
                    n_state  = S_EDIV;
                    n_cnt    = '0;
                end
                if (i_sts.right && !i_sts.skip) begin
                    o_cmd.op = OP_TOG;
                    n_state  = S_ENEXT;
                end
            end
            S_EMUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.sel    = SEL_EDGE;
                n_state      = S_EXC;
            end
            S_EXC: begin
                o_cmd.op = OP_XC;
                n_state  = S_ENEXT;
            end
            S_ENEXT: begin
                o_cmd.op = OP_ESHIFT;
                if (last_edge) begin
                    n_state = S_DONE;
                end else begin
                    n_eidx      = r_eidx + AW'(1);
                    o_cmd.rd_en = 1'b1;
                    o_rd_idx    = (nxt2 < EW'(i_n_edges)) ? AW'(nxt2) : '0;
                    n_state     = S_ECLS;
                end
            end
            S_DONE: begin
                o_cmd.op = OP_RES;
                n_state  = S_IDLE;
            end
            S_MISS: begin
                o_cmd.op = OP_ZERO;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/rpi_dpath.sv
// ----------------------------------------------------------------------------
// rpi_dpath
// Datapath: configuration, vertex memory, shared multiplier, bit-serial
// divider, edge classification and result register.
// ----------------------------------------------------------------------------
module rpi_dpath #(
    parameter int MAX_VERTICES = rpi_pkg::MAX_VERTICES_DEF,
    parameter int AW = 4,
    parameter int CW = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rpi_pkg::t_cmd       i_cmd,
    input  logic [AW-1:0]       i_rd_idx,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [17:0]         i_cfg_data,
    input  logic [3:0]          i_vertex_slot,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    input  logic signed [31:0]  i_dir_x,
    input  logic signed [31:0]  i_dir_y,
    input  logic signed [31:0]  i_dir_z,
    input  logic signed [31:0]  i_t_low,
    input  logic signed [31:0]  i_t_high,
    output rpi_pkg::t_sts       o_sts,
    output logic [CW-1:0]       o_n_edges,
    output logic                o_done,
    output logic                o_hit_found,
    output logic                o_entering,
    output logic signed [31:0]  o_hit_distance
);
    import rpi_pkg::*;

    // configuration
    logic signed [17:0] r_nx, r_ny, r_nz;
    logic [1:0]         r_axis;
    logic [4:0]         r_vcount;
    logic [15:0]        r_eps;

    // vertex memory
    logic [95:0]        r_mem [MAX_VERTICES];
    logic [95:0]        r_vert;

    // ray
    logic signed [31:0] r_ox, r_oy, r_oz, r_dx, r_dy, r_dz, r_tlo, r_thi;

    // arithmetic
    logic signed [65:0] r_prod;
    logic signed [53:0] r_acc, r_den, r_num;
    logic [52:0]        r_rem, r_dvs;
    logic [31:0]        r_nlo, r_q;
    logic               r_sat;
    logic signed [31:0] r_t;
    logic signed [49:0] r_px, r_py;
    logic signed [31:0] r_x0, r_y0;
    logic               r_inside;

    logic signed [31:0] vx, vy, vz, va, vb, org_a, org_b, dir_a, dir_b;
    logic signed [32:0] ma, mb;
    logic [52:0]        ad, an;
    logic [53:0]        trial, tdiff;
    logic               tge;
    logic [32:0]        tm;
    logic               tneg;
    logic signed [31:0] t_val;
    logic signed [50:0] ey;
    logic [50:0]        ey_abs;
    logic signed [33:0] dyy;
    logic [33:0]        dyy_abs;
    logic signed [49:0] x0s, y0s, x1s, y1s, xc;
    logic               slot_ok;

    assign vx = signed'(r_vert[31:0]);
    assign vy = signed'(r_vert[63:32]);
    assign vz = signed'(r_vert[95:64]);

    always_comb begin
        if (r_axis == AXIS_X) begin
            va = vy;   vb = vz;
            org_a = r_oy; org_b = r_oz;
            dir_a = r_dy; dir_b = r_dz;
        end else if (r_axis == AXIS_Y) begin
            va = vx;   vb = vz;
            org_a = r_ox; org_b = r_oz;
            dir_a = r_dx; dir_b = r_dz;
        end else begin
            va = vx;   vb = vy;
            org_a = r_ox; org_b = r_oy;
            dir_a = r_dx; dir_b = r_dy;
        end
    end

    assign o_n_edges = (32'(r_vcount) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(r_vcount);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx     <= '0;
            r_ny     <= '0;
            r_nz     <= 18'sd65536;
            r_axis   <= 2'd2;
            r_vcount <= 5'd3;
            r_eps    <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NORMAL_X: r_nx     <= signed'(i_cfg_data);
                CFG_NORMAL_Y: r_ny     <= signed'(i_cfg_data);
                CFG_NORMAL_Z: r_nz     <= signed'(i_cfg_data);
                CFG_AXIS:     r_axis   <= i_cfg_data[1:0];
                CFG_VCOUNT:   r_vcount <= i_cfg_data[4:0];
                CFG_EPS:      r_eps    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign slot_ok = (32'(i_vertex_slot) < MAX_VERTICES);

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD && slot_ok) begin
            r_mem[AW'(i_vertex_slot)] <= {i_pos_z, i_pos_y, i_pos_x};
        end
        if (i_cmd.rd_en) begin
            r_vert <= r_mem[i_rd_idx];
        end
    end

    always_comb begin
        ma = 33'(r_nx);
        mb = 33'(r_dx);
        case (i_cmd.sel)
            SEL_NXDX: begin ma = 33'(r_nx); mb = 33'(r_dx); end
            SEL_NYDY: begin ma = 33'(r_ny); mb = 33'(r_dy); end
            SEL_NZDZ: begin ma = 33'(r_nz); mb = 33'(r_dz); end
            SEL_NXOX: begin ma = 33'(r_nx); mb = 33'(r_ox) - 33'(vx); end
            SEL_NYOY: begin ma = 33'(r_ny); mb = 33'(r_oy) - 33'(vy); end
            SEL_NZOZ: begin ma = 33'(r_nz); mb = 33'(r_oz) - 33'(vz); end
            SEL_DA_T: begin ma = 33'(dir_a); mb = 33'(r_t); end
            SEL_DB_T: begin ma = 33'(dir_b); mb = 33'(r_t); end
            SEL_EDGE: begin ma = 33'(va) - 33'(r_x0); mb = signed'({1'b0, r_q}); end
            default: ;
        endcase
    end

    assign ad = r_den[53] ? 53'(-r_den) : r_den[52:0];
    assign an = r_num[53] ? 53'(-r_num) : r_num[52:0];

    assign trial = {r_rem, r_nlo[31]};
    assign tdiff = trial - {1'b0, r_dvs};
    assign tge   = (trial >= {1'b0, r_dvs});

    assign tm    = r_sat ? 33'h1_0000_0000 : {1'b0, r_q};
    assign tneg  = (r_num != '0) && (r_num[53] == r_den[53]);
    always_comb begin
        if (tneg) begin
            t_val = (tm > 33'h0_8000_0000) ? 32'sh8000_0000 : signed'(32'(~tm + 33'd1));
        end else begin
            t_val = (tm > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(tm[31:0]);
        end
    end

    assign ey      = 51'(r_y0) - 51'(r_py);
    assign ey_abs  = ey[50] ? unsigned'(-ey) : unsigned'(ey);
    assign dyy     = 34'(r_y0) - 34'(vb);
    assign dyy_abs = dyy[33] ? unsigned'(-dyy) : unsigned'(dyy);

    assign x0s = 50'(r_x0);
    assign y0s = 50'(r_y0);
    assign x1s = 50'(va);
    assign y1s = 50'(vb);
    assign xc  = x0s + 50'(r_prod >>> 16);

    assign o_sts.par   = (ad == '0) || (ad < 53'({r_eps, 16'd0}));
    assign o_sts.rng   = (r_t < r_tlo) || (r_t > r_thi);
    assign o_sts.skip  = (y0s < r_py && y1s < r_py) || (y0s > r_py && y1s > r_py)
                       || (x0s < r_px && x1s < r_px);
    assign o_sts.right = (x0s > r_px && x1s > r_px);
    assign o_sts.horiz = (r_y0 == vb);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= ma * mb;
        end
        case (i_cmd.acc)
            ACC_LOAD: r_acc <= signed'(r_prod[53:0]);
            ACC_ADD:  r_acc <= r_acc + signed'(r_prod[53:0]);
            default: ;
        endcase
        case (i_cmd.op)
            OP_CAPT: begin
                r_ox <= i_pos_x;  r_oy <= i_pos_y;  r_oz <= i_pos_z;
                r_dx <= i_dir_x;  r_dy <= i_dir_y;  r_dz <= i_dir_z;
                r_tlo <= i_t_low; r_thi <= i_t_high;
                r_inside <= 1'b0;
            end
            OP_DEN: r_den <= r_acc;
            OP_NUM: r_num <= r_acc;
            OP_DIVT: begin
                r_rem <= 53'(an >> 16);
                r_nlo <= {an[15:0], 16'd0};
                r_dvs <= ad;
                r_q   <= '0;
                r_sat <= ({16'd0, an} >= {ad, 16'd0});
            end
            OP_DIVE: begin
                r_rem <= 53'(ey_abs[32:16]);
                r_nlo <= {ey_abs[15:0], 16'd0};
                r_dvs <= 53'(dyy_abs[32:0]);
                r_q   <= '0;
            end
            OP_DSTEP: begin
                r_rem <= tge ? tdiff[52:0] : trial[52:0];
                r_nlo <= {r_nlo[30:0], 1'b0};
                r_q   <= {r_q[30:0], tge};
            end
            OP_TFIN:   r_t <= t_val;
            OP_PX:     r_px <= 50'(org_a) + 50'(r_prod >>> 16);
            OP_PY:     r_py <= 50'(org_b) + 50'(r_prod >>> 16);
            OP_ESHIFT: begin
                r_x0 <= va;
                r_y0 <= vb;
            end
            OP_TOG:    r_inside <= ~r_inside;
            OP_XC:     r_inside <= r_inside ^ (r_px < xc);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= (i_cmd.op == OP_LOAD) || (i_cmd.op == OP_RES) || (i_cmd.op == OP_ZERO);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_RES) begin
            o_hit_found    <= r_inside;
            o_entering     <= r_inside & r_den[53];
            o_hit_distance <= r_inside ? r_t : '0;
        end else if (i_cmd.op == OP_LOAD || i_cmd.op == OP_ZERO) begin
            o_hit_found    <= 1'b0;
            o_entering     <= 1'b0;
            o_hit_distance <= '0;
        end
    end

endmodule

FILE: hdl/ray_polygon_intersect_top.sv
// ----------------------------------------------------------------------------
// ray_polygon_intersect_top
// Ray / polygon intersection with an even-odd crossing test, Q16.16.
//
//   channel   handshake              payload
//   input     start, busy            i_func .. i_t_high
//   result    o_done (strobe)        o_hit_found, o_entering, o_hit_distance
//   config    i_cfg_we               i_cfg_idx, i_cfg_data
//
// A load beat leaves busy low; its result strobes on the next cycle.
// A test beat holds busy over the whole sequence, and each edge that needs
// the 32-step divider adds its steps to it; one shared divider and one shared
// 33x33 multiplier serve all of these steps. A parallel miss or a t out of
// range ends the test early. o_done is high in the first cycle busy is low.
// Reset is synchronous, active low. The receiver cannot stall o_done.
// ----------------------------------------------------------------------------
module ray_polygon_intersect_top #(
    parameter int MAX_VERTICES = rpi_pkg::MAX_VERTICES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_func,
    input  logic [3:0]         i_vertex_slot,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    input  logic signed [31:0] i_t_low,
    input  logic signed [31:0] i_t_high,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [17:0]        i_cfg_data,
    output logic               o_done,
    output logic               o_hit_found,
    output logic               o_entering,
    output logic signed [31:0] o_hit_distance
);
    import rpi_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    t_cmd          cmd;
    t_sts          sts;
    logic [AW-1:0] rd_idx;
    logic [CW-1:0] n_edges;

    rpi_ctrl #(
        .AW(AW),
        .CW(CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_func    (i_func),
        .i_sts     (sts),
        .i_n_edges (n_edges),
        .o_cmd     (cmd),
        .o_rd_idx  (rd_idx),
        .busy      (busy)
    );

    rpi_dpath #(
        .MAX_VERTICES(MAX_VERTICES),
        .AW(AW),
        .CW(CW)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_rd_idx       (rd_idx),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_vertex_slot  (i_vertex_slot),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_dir_x        (i_dir_x),
        .i_dir_y        (i_dir_y),
        .i_dir_z        (i_dir_z),
        .i_t_low        (i_t_low),
        .i_t_high       (i_t_high),
        .o_sts          (sts),
        .o_n_edges      (n_edges),
        .o_done         (o_done),
        .o_hit_found    (o_hit_found),
        .o_entering     (o_entering),
        .o_hit_distance (o_hit_distance)
    );

`ifndef SYNTHESIS
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_LOAD) |=> (o_done && !o_hit_found))
        else $error("load beat without result");

    a_test_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_TEST) |=> busy)
        else $error("test beat did not start work");

    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("test ended without result");

    a_enter_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_entering) |-> o_hit_found)
        else $error("entering flagged on a miss");
`endif

endmodule
